// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared types and constants for the sorted set table and its cell chain.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int OP_W     = 4;
    localparam int KEY_IN_W = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 4'd0,
        OP_REMOVE   = 4'd1,
        OP_EXISTS   = 4'd2,
        OP_MIN      = 4'd3,
        OP_MAX      = 4'd4,
        OP_POP_MIN  = 4'd5,
        OP_POP_MAX  = 4'd6,
        OP_PRED     = 4'd7,
        OP_SUCC     = 4'd8,
        OP_POP_PRED = 4'd9,
        OP_POP_SUCC = 4'd10,
        OP_CLEAR    = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [KEY_IN_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    typedef struct packed {
        logic occ;
        logic lt;
        logic le;
        logic eq;
    } cell_flags_t;

    typedef struct packed {
        logic            cmp_en;
        logic            write_en;
        logic [OP_W-1:0] op;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/sst_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted set table cell
// One slot of the sorted chain: holds a key, compares it with the search key,
// flags itself as the hit for the current request and shifts keys to or from
// its neighbors when an entry is inserted or removed.
// ----------------------------------------------------------------------------
module sst_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  sst_pkg::cell_ctrl_t   ctrl,
    input  logic [KEY_WIDTH-1:0]  search_key,
    input  logic [CNT_W-1:0]      count,
    input  sst_pkg::cell_flags_t  prev_flags,
    input  sst_pkg::cell_flags_t  next_flags,
    input  logic [KEY_WIDTH-1:0]  prev_key,
    input  logic [KEY_WIDTH-1:0]  next_key,
    output logic [KEY_WIDTH-1:0]  key,
    output sst_pkg::cell_flags_t  flags,
    output logic                  hit,
    output logic [KEY_WIDTH-1:0]  hit_key
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    sst_pkg::cell_flags_t flags_reg;
    sst_pkg::cell_flags_t flags_next;
    logic                 occ_now;

    always_comb
    begin
        occ_now    = CNT_W'(INDEX) < count;
        flags_next = flags_reg;
        if (ctrl.cmp_en)
        begin
            flags_next.occ = occ_now;
            flags_next.lt  = occ_now && (key_reg < search_key);
            flags_next.le  = occ_now && (key_reg <= search_key);
            flags_next.eq  = occ_now && (key_reg == search_key);
        end
    end

    always_comb
    begin
        case (ctrl.op)
            sst_pkg::OP_INSERT,
            sst_pkg::OP_REMOVE,
            sst_pkg::OP_EXISTS:
                hit = flags_reg.eq;
            sst_pkg::OP_MIN,
            sst_pkg::OP_POP_MIN:
                hit = (INDEX == 0) && flags_reg.occ;
            sst_pkg::OP_MAX,
            sst_pkg::OP_POP_MAX:
                hit = flags_reg.occ && !next_flags.occ;
            sst_pkg::OP_PRED,
            sst_pkg::OP_POP_PRED:
                hit = flags_reg.lt && !next_flags.lt;
            sst_pkg::OP_SUCC,
            sst_pkg::OP_POP_SUCC:
                hit = flags_reg.occ && !flags_reg.le && prev_flags.le;
            default:
                hit = 1'b0;
        endcase
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.write_en)
        begin
            case (ctrl.op)
                sst_pkg::OP_INSERT:
                    if (!flags_reg.lt)
                    begin
                        key_next = prev_flags.lt ? search_key : prev_key;
                    end
                sst_pkg::OP_REMOVE:
                    if (!flags_reg.lt)
                    begin
                        key_next = next_key;
                    end
                sst_pkg::OP_POP_MIN:
                    key_next = next_key;
                sst_pkg::OP_POP_PRED:
                    if (!next_flags.lt)
                    begin
                        key_next = next_key;
                    end
                sst_pkg::OP_POP_SUCC:
                    if (!flags_reg.le)
                    begin
                        key_next = next_key;
                    end
                default:
                    key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        flags_reg <= flags_next;
    end

    assign key     = key_reg;
    assign flags   = flags_reg;
    assign hit_key = hit ? key_reg : '0;

endmodule

// ===== rtl/core/sorted_set_table.sv =====
// ----------------------------------------------------------------------------
// Sorted set table
// Ordered set of distinct keys held ascending in a chain of cells, with
// insert, remove, lookup, minimum, maximum, neighbor search, pops and clear.
//
//   Channel   Handshake        Payload   Transfer taken when
//   request   start / busy     req       start high and busy low at a clock edge
//   result    done (strobe)    rsp       done high at a clock edge, one cycle
//
// Each request goes from its transfer to the done strobe through these steps in
// order: latch it, let every cell compare its key, pick the hit cell and reduce
// its key, and shift the chain of cells and write the result into rsp.
// A new request is taken on the edge where done is shown. After reset the
// table is empty and ready at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module sorted_set_table #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::req_t req,
    output logic          done,
    output sst_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sst_pkg::state_t      state_reg;
    sst_pkg::state_t      state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    logic                 done_next;
    logic [sst_pkg::OP_W-1:0] op_reg;
    logic [sst_pkg::OP_W-1:0] op_next;
    logic [KEY_WIDTH-1:0] skey_reg;
    logic [KEY_WIDTH-1:0] skey_next;
    logic                 found_reg;
    logic                 found_next;
    logic [KEY_WIDTH-1:0] hit_key_reg;
    logic [KEY_WIDTH-1:0] hit_key_next;
    sst_pkg::rsp_t        rsp_reg;
    sst_pkg::rsp_t        rsp_next;

    sst_pkg::cell_ctrl_t  ctrl;
    logic                 accept;
    logic                 full;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 hit_any;
    logic [KEY_WIDTH-1:0] hit_or;

    logic [KEY_WIDTH-1:0] cell_key     [CAPACITY];
    sst_pkg::cell_flags_t cell_flags   [CAPACITY];
    logic                 cell_hit     [CAPACITY];
    logic [KEY_WIDTH-1:0] cell_hit_key [CAPACITY];
    sst_pkg::cell_flags_t prev_flags_w [CAPACITY];
    sst_pkg::cell_flags_t next_flags_w [CAPACITY];
    logic [KEY_WIDTH-1:0] prev_key_w   [CAPACITY];
    logic [KEY_WIDTH-1:0] next_key_w   [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prev_flags_w[gi] = '{occ: 1'b1, lt: 1'b1, le: 1'b1, eq: 1'b0};
                assign prev_key_w[gi]   = '0;
            end
            else
            begin : g_mid_prev
                assign prev_flags_w[gi] = cell_flags[gi-1];
                assign prev_key_w[gi]   = cell_key[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_flags_w[gi] = '{occ: 1'b0, lt: 1'b0, le: 1'b0, eq: 1'b0};
                assign next_key_w[gi]   = '0;
            end
            else
            begin : g_mid_next
                assign next_flags_w[gi] = cell_flags[gi+1];
                assign next_key_w[gi]   = cell_key[gi+1];
            end

            sst_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .search_key (skey_reg),
                .count      (count_reg),
                .prev_flags (prev_flags_w[gi]),
                .next_flags (next_flags_w[gi]),
                .prev_key   (prev_key_w[gi]),
                .next_key   (next_key_w[gi]),
                .key        (cell_key[gi]),
                .flags      (cell_flags[gi]),
                .hit        (cell_hit[gi]),
                .hit_key    (cell_hit_key[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_any = 1'b0;
        hit_or  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any = hit_any | cell_hit[i];
            hit_or  = hit_or | cell_hit_key[i];
        end
    end

    assign accept = start && (state_reg == sst_pkg::ST_IDLE);
    assign full   = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        op_next      = op_reg;
        skey_next    = skey_reg;
        found_next   = found_reg;
        hit_key_next = hit_key_reg;
        rsp_next     = rsp_reg;
        ins_ok       = 1'b0;
        del_ok       = 1'b0;

        case (state_reg)
            sst_pkg::ST_IDLE:
                if (accept)
                begin
                    op_next    = req.operation;
                    skey_next  = KEY_WIDTH'(req.key);
                    state_next = sst_pkg::ST_CMP;
                end
            sst_pkg::ST_CMP:
                state_next = sst_pkg::ST_SEL;
            sst_pkg::ST_SEL:
            begin
                found_next   = hit_any;
                hit_key_next = hit_or;
                state_next   = sst_pkg::ST_WRITE;
            end
            sst_pkg::ST_WRITE:
            begin
                rsp_next.value  = '0;
                rsp_next.status = sst_pkg::STATUS_OK;
                case (op_reg)
                    sst_pkg::OP_INSERT:
                        if (found_reg)
                        begin
                            rsp_next.value  = sst_pkg::VALUE_W'(skey_reg);
                            rsp_next.status = sst_pkg::STATUS_DUP;
                        end
                        else if (full)
                        begin
                            rsp_next.status = sst_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ins_ok         = 1'b1;
                            rsp_next.value = sst_pkg::VALUE_W'(skey_reg);
                        end
                    sst_pkg::OP_REMOVE,
                    sst_pkg::OP_POP_MIN,
                    sst_pkg::OP_POP_MAX,
                    sst_pkg::OP_POP_PRED,
                    sst_pkg::OP_POP_SUCC,
                    sst_pkg::OP_EXISTS,
                    sst_pkg::OP_MIN,
                    sst_pkg::OP_MAX,
                    sst_pkg::OP_PRED,
                    sst_pkg::OP_SUCC:
                        if (found_reg)
                        begin
                            rsp_next.value = sst_pkg::VALUE_W'(hit_key_reg);
                            del_ok = (op_reg inside {sst_pkg::OP_REMOVE, sst_pkg::OP_POP_MIN,
                                                     sst_pkg::OP_POP_MAX, sst_pkg::OP_POP_PRED,
                                                     sst_pkg::OP_POP_SUCC});
                        end
                        else
                        begin
                            rsp_next.status = sst_pkg::STATUS_ABSENT;
                        end
                    sst_pkg::OP_CLEAR:
                        count_next = '0;
                    default:
                        count_next = count_reg;
                endcase
                if (ins_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (del_ok)
                begin
                    count_next = count_reg - 1'b1;
                end
                rsp_next.count = sst_pkg::COUNT_W'(count_next);
                done_next      = 1'b1;
                state_next     = sst_pkg::ST_IDLE;
            end
            default:
                state_next = sst_pkg::ST_IDLE;
        endcase

        ctrl.cmp_en   = state_reg == sst_pkg::ST_CMP;
        ctrl.write_en = (state_reg == sst_pkg::ST_WRITE) && (ins_ok || del_ok);
        ctrl.op       = op_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        skey_reg    <= skey_next;
        found_reg   <= found_next;
        hit_key_reg <= hit_key_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = state_reg != sst_pkg::ST_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe missing four cycles after request transfer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in progress");

    a_write_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.write_en |-> (state_reg == sst_pkg::ST_WRITE) && (count_next != count_reg))
        else $error("chain shift without a count change");

endmodule
